### rtl/core/olm_pkg.sv
// ----------------------------------------------------------------------------
// olm_pkg
// Shared codes, types and defaults for the ordered list manager.
// ----------------------------------------------------------------------------
package olm_pkg;

    localparam int OLM_CAPACITY   = 64;
    localparam int OLM_DATA_WIDTH = 32;

    localparam int FUNC_W = 4;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT   = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK    = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_BEFORE = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_AFTER = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT    = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK     = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_READ_AT      = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_ERASE        = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR        = 4'd8;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_FULL      = 3'd4
    } olm_status_t;

    // Update broadcast to every cell of the chain
    typedef enum logic [3:0] {
        MODE_HOLD,
        MODE_CLEAR,
        MODE_INS_FRONT,
        MODE_INS_BACK,
        MODE_INS_BEFORE,
        MODE_INS_AFTER,
        MODE_DEL_FRONT,
        MODE_DEL_BACK,
        MODE_DEL_KEY
    } olm_mode_t;

endpackage

### rtl/core/olm_cell.sv
// ----------------------------------------------------------------------------
// olm_cell
// One list position: holds a value and an occupied flag, takes part in the
// key-search chain, the shift update and the read-out chains.
// ----------------------------------------------------------------------------
module olm_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  olm_pkg::olm_mode_t      mode,
    input  logic [DATA_WIDTH-1:0]   key,
    input  logic [DATA_WIDTH-1:0]   new_value,
    input  logic [POS_W-1:0]        pos,
    input  logic [DATA_WIDTH-1:0]   left_val,
    input  logic                    left_occ,
    input  logic                    left_first,
    input  logic                    left_seen,
    input  logic [DATA_WIDTH-1:0]   right_val,
    input  logic                    right_occ,
    input  logic [DATA_WIDTH-1:0]   right_rd,
    input  logic [DATA_WIDTH-1:0]   right_bk,
    output logic [DATA_WIDTH-1:0]   val,
    output logic                    occ,
    output logic                    first,
    output logic                    seen_out,
    output logic [DATA_WIDTH-1:0]   rd,
    output logic [DATA_WIDTH-1:0]   bk
);
    import olm_pkg::*;

    localparam logic [POS_W-1:0] IDX_L = IDX[POS_W-1:0];
    localparam logic             IS_HEAD = (IDX == 0);

    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  occ_reg, occ_next;
    logic                  seen_reg;
    logic [DATA_WIDTH-1:0] rd_reg, bk_reg;
    logic                  match;
    logic                  at, beyond, shift, kill;

    assign match    = occ_reg && (val_reg == key);
    assign first    = match && !seen_reg;
    assign seen_out = seen_reg || match;

    always_comb
    begin
        at     = 1'b0;
        beyond = 1'b0;
        shift  = 1'b0;
        kill   = 1'b0;
        unique case (mode)
            MODE_HOLD:       ;
            MODE_CLEAR:      kill = 1'b1;
            MODE_INS_FRONT:
            begin
                at     = IS_HEAD;
                beyond = !IS_HEAD;
            end
            MODE_INS_BACK:   at = !occ_reg && left_occ;
            MODE_INS_BEFORE:
            begin
                at     = first;
                beyond = seen_reg;
            end
            MODE_INS_AFTER:
            begin
                at     = left_first;
                beyond = seen_reg && !left_first;
            end
            MODE_DEL_FRONT:  shift = 1'b1;
            MODE_DEL_BACK:   kill = occ_reg && !right_occ;
            MODE_DEL_KEY:    shift = first || seen_reg;
            default:         ;
        endcase

        val_next = val_reg;
        occ_next = occ_reg;
        if (at)
        begin
            val_next = new_value;
            occ_next = 1'b1;
        end
        else if (beyond)
        begin
            val_next = left_val;
            occ_next = left_occ;
        end
        else if (shift)
        begin
            val_next = right_val;
            occ_next = right_occ;
        end
        else if (kill)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            seen_reg <= left_seen;
        end
    end

    // Read-out chains drift one cell towards the head each cycle
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rd_reg  <= (occ_reg && (pos == IDX_L)) ? val_reg : right_rd;
        bk_reg  <= (occ_reg && !right_occ) ? val_reg : right_bk;
    end

    assign val = val_reg;
    assign occ = occ_reg;
    assign rd  = rd_reg;
    assign bk  = bk_reg;

endmodule

### rtl/core/ordered_list_manager_core.sv
// ----------------------------------------------------------------------------
// ordered_list_manager_core
// Ordered list of up to CAPACITY values kept in a chain of position cells.
// ----------------------------------------------------------------------------
// Transactions are handled one at a time in three phases: a search pass
// along the cell chain finds the first value equal to the key, an apply step
// makes the update (cells shift towards or away from the head), and a
// read-out pass brings the requested value and the back value to the head
// of the chain.
// in_stall is high while a transaction is in flight or its result waits.
module ordered_list_manager_core #(
    parameter int CAPACITY   = olm_pkg::OLM_CAPACITY,
    parameter int DATA_WIDTH = olm_pkg::OLM_DATA_WIDTH,
    localparam int POS_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [olm_pkg::FUNC_W-1:0] func,
    input  logic [DATA_WIDTH-1:0]      search_key,
    input  logic [DATA_WIDTH-1:0]      new_value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [olm_pkg::STAT_W-1:0] status,
    output logic [DATA_WIDTH-1:0]      read_data,
    output logic [DATA_WIDTH-1:0]      front_value,
    output logic [DATA_WIDTH-1:0]      back_value,
    output logic [CNT_W-1:0]           entry_count,
    output logic                       is_empty
);
    import olm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_GATHER, S_OUT} state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      cyc_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] key_reg, value_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    olm_status_t           stat_reg, stat_next;
    olm_mode_t             apply_mode, mode;

    logic [STAT_W-1:0]     status_reg;
    logic [DATA_WIDTH-1:0] read_data_reg, front_reg, back_reg;
    logic                  out_valid_reg;

    logic [DATA_WIDTH-1:0] c_val   [CAPACITY];
    logic                  c_occ   [CAPACITY];
    logic                  c_first [CAPACITY];
    logic                  c_seen  [CAPACITY];
    logic [DATA_WIDTH-1:0] c_rd    [CAPACITY];
    logic [DATA_WIDTH-1:0] c_bk    [CAPACITY];

    logic found, full, empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            olm_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .POS_W      (POS_W),
                .IDX        (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .mode       (mode),
                .key        (key_reg),
                .new_value  (value_reg),
                .pos        (pos_reg),
                .left_val   ((gi == 0) ? '0   : c_val[(gi == 0) ? 0 : gi-1]),
                .left_occ   ((gi == 0) ? 1'b1 : c_occ[(gi == 0) ? 0 : gi-1]),
                .left_first ((gi == 0) ? 1'b0 : c_first[(gi == 0) ? 0 : gi-1]),
                .left_seen  ((gi == 0) ? 1'b0 : c_seen[(gi == 0) ? 0 : gi-1]),
                .right_val  ((gi == CAPACITY-1) ? '0 : c_val[(gi == CAPACITY-1) ? gi : gi+1]),
                .right_occ  ((gi == CAPACITY-1) ? 1'b0 : c_occ[(gi == CAPACITY-1) ? gi : gi+1]),
                .right_rd   ((gi == CAPACITY-1) ? '0 : c_rd[(gi == CAPACITY-1) ? gi : gi+1]),
                .right_bk   ((gi == CAPACITY-1) ? '0 : c_bk[(gi == CAPACITY-1) ? gi : gi+1]),
                .val        (c_val[gi]),
                .occ        (c_occ[gi]),
                .first      (c_first[gi]),
                .seen_out   (c_seen[gi]),
                .rd         (c_rd[gi]),
                .bk         (c_bk[gi])
            );
        end
    endgenerate

    // The tail of the search chain says whether any cell matched
    assign found = c_seen[CAPACITY-1];
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        apply_mode = MODE_HOLD;
        stat_next  = ST_OK;
        count_next = count_reg;
        case (func_reg) inside
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
            begin
                if (full)
                    stat_next = ST_FULL;
                else
                begin
                    apply_mode = (func_reg == FUNC_PUSH_FRONT) ? MODE_INS_FRONT
                                                               : MODE_INS_BACK;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_INSERT_BEFORE, FUNC_INSERT_AFTER:
            begin
                if (!found)
                    stat_next = ST_NOT_FOUND;
                else if (full)
                    stat_next = ST_FULL;
                else
                begin
                    apply_mode = (func_reg == FUNC_INSERT_BEFORE) ? MODE_INS_BEFORE
                                                                  : MODE_INS_AFTER;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK:
            begin
                if (empty)
                    stat_next = ST_EMPTY;
                else
                begin
                    apply_mode = (func_reg == FUNC_POP_FRONT) ? MODE_DEL_FRONT
                                                              : MODE_DEL_BACK;
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_READ_AT:
            begin
                if (CNT_W'(pos_reg) >= count_reg)
                    stat_next = ST_BAD_POS;
            end
            FUNC_ERASE:
            begin
                if (!found)
                    stat_next = ST_NOT_FOUND;
                else
                begin
                    apply_mode = MODE_DEL_KEY;
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                apply_mode = MODE_CLEAR;
                count_next = '0;
            end
            default: ;
        endcase
    end

    assign mode = (state_reg == S_APPLY) ? apply_mode : MODE_HOLD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cyc_reg       <= '0;
            count_reg     <= '0;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                        cyc_reg   <= CNT_W'(CAPACITY - 1);
                    end
                end
                S_SCAN:
                begin
                    if (cyc_reg == '0)
                        state_reg <= S_APPLY;
                    else
                        cyc_reg <= cyc_reg - 1'b1;
                end
                S_APPLY:
                begin
                    stat_reg  <= stat_next;
                    count_reg <= count_next;
                    cyc_reg   <= CNT_W'(CAPACITY);
                    state_reg <= S_GATHER;
                end
                S_GATHER:
                begin
                    if (cyc_reg == '0)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                        cyc_reg <= cyc_reg - 1'b1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Hold the transaction and the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg  <= func;
            key_reg   <= search_key;
            value_reg <= new_value;
            pos_reg   <= position;
        end
        if (state_reg == S_GATHER && cyc_reg == '0)
        begin
            status_reg    <= stat_reg;
            read_data_reg <= (func_reg == FUNC_READ_AT && stat_reg == ST_OK) ? c_rd[0] : '0;
            front_reg     <= c_occ[0] ? c_val[0] : '0;
            back_reg      <= c_bk[0];
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_data   = read_data_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !out_valid))
        else $error("not busy after accepting a transaction");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (front_value == '0 && back_value == '0))
        else $error("empty list shows a front or back value");

    a_head_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (c_occ[0] == (count_reg != '0)))
        else $error("head cell occupancy disagrees with count");

endmodule

### bench/olm_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olm_list_checker
// Watches both channels of the ordered list manager. It keeps a shadow list
// of the held values, predicts the result of each accepted transaction and
// compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module olm_list_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [olm_pkg::FUNC_W-1:0]  func,
    input  logic [31:0]                 search_key,
    input  logic [31:0]                 new_value,
    input  logic [5:0]                  position,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [olm_pkg::STAT_W-1:0]  status,
    input  logic [31:0]                 read_data,
    input  logic [31:0]                 front_value,
    input  logic [31:0]                 back_value,
    input  logic [6:0]                  entry_count,
    input  logic                        is_empty,
    output int                          fail_count,
    output int                          pending_count
);
    import olm_pkg::*;

    typedef struct packed {
        olm_status_t status;
        logic [31:0] read_data;
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [6:0]  entry_count;
        logic        is_empty;
    } list_result_t;

    logic [31:0]  shadow_list[$];
    list_result_t expected_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what,
                     got, want);
            fail_count++;
        end
    endtask

    function automatic int find_first(input logic [31:0] key);
        int idx;
        begin
            find_first = -1;
            for (idx = 0; idx < shadow_list.size(); idx++)
            begin
                if (shadow_list[idx] == key)
                begin
                    find_first = idx;
                    break;
                end
            end
        end
    endfunction

    // Apply one operation to the shadow list and work out its result.
    task automatic apply_list_op(input logic [FUNC_W-1:0] op, input logic [31:0] key,
                                 input logic [31:0] val, input logic [5:0] pos);
        list_result_t res;
        int           hit;
        logic         full;
        begin
            res = '0;
            res.status = ST_OK;
            full = shadow_list.size() >= OLM_CAPACITY;
            case (op) inside
                FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                begin
                    if (full)
                        res.status = ST_FULL;
                    else if (op == FUNC_PUSH_FRONT)
                        shadow_list.insert(0, val);
                    else
                        shadow_list.insert(shadow_list.size(), val);
                end
                FUNC_INSERT_BEFORE, FUNC_INSERT_AFTER:
                begin
                    hit = find_first(key);
                    if (hit < 0)
                        res.status = ST_NOT_FOUND;
                    else if (full)
                        res.status = ST_FULL;
                    else if (op == FUNC_INSERT_BEFORE)
                        shadow_list.insert(hit, val);
                    else
                        shadow_list.insert(hit + 1, val);
                end
                FUNC_POP_FRONT, FUNC_POP_BACK:
                begin
                    if (shadow_list.size() == 0)
                        res.status = ST_EMPTY;
                    else if (op == FUNC_POP_FRONT)
                        shadow_list.delete(0);
                    else
                        shadow_list.delete(shadow_list.size() - 1);
                end
                FUNC_READ_AT:
                begin
                    if (pos >= shadow_list.size())
                        res.status = ST_BAD_POS;
                    else
                        res.read_data = shadow_list[pos];
                end
                FUNC_ERASE:
                begin
                    hit = find_first(key);
                    if (hit < 0)
                        res.status = ST_NOT_FOUND;
                    else
                        shadow_list.delete(hit);
                end
                FUNC_CLEAR:
                    shadow_list.delete();
                default: ;
            endcase
            res.entry_count = 7'(shadow_list.size());
            res.is_empty = (shadow_list.size() == 0);
            if (shadow_list.size() != 0)
            begin
                res.front_value = shadow_list[0];
                res.back_value = shadow_list[$];
            end
            expected_results.insert(expected_results.size(), res);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_list_op(func, search_key, new_value, position);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (status != want.status)
                        report_mismatch("status", status, want.status);
                    if (read_data != want.read_data)
                        report_mismatch("read_data", read_data, want.read_data);
                    if (front_value != want.front_value)
                        report_mismatch("front_value", front_value, want.front_value);
                    if (back_value != want.back_value)
                        report_mismatch("back_value", back_value, want.back_value);
                    if (entry_count != want.entry_count)
                        report_mismatch("entry_count", entry_count, want.entry_count);
                    if (is_empty != want.is_empty)
                        report_mismatch("is_empty", is_empty, want.is_empty);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### bench/ordered_list_manager_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_manager_core_test
// Drives directed and random list operations into the ordered list manager
// with random gaps and output back-pressure; the checker predicts each result.
// ----------------------------------------------------------------------------
module ordered_list_manager_core_test;
    import olm_pkg::*;

    localparam int RANDOM_OPS = 1430;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [31:0]         search_key;
    logic [31:0]         new_value;
    logic [5:0]          position;
    logic                out_valid;
    logic                out_stall;
    logic [STAT_W-1:0]   status;
    logic [31:0]         read_data;
    logic [31:0]         front_value;
    logic [31:0]         back_value;
    logic [6:0]          entry_count;
    logic                is_empty;
    int                  fail_count;
    int                  pending_count;
    logic                sending_done;
    logic [31:0]         value_pool[12];

    ordered_list_manager_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .search_key(search_key), .new_value(new_value), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_data(read_data), .front_value(front_value),
        .back_value(back_value), .entry_count(entry_count), .is_empty(is_empty)
    );

    olm_list_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .search_key(search_key), .new_value(new_value), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_data(read_data), .front_value(front_value),
        .back_value(back_value), .entry_count(entry_count), .is_empty(is_empty),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_length();
        begin
            if ($urandom_range(0, 19) == 0)
                gap_length = $urandom_range(20, 150);
            else
                gap_length = $urandom_range(0, 3);
        end
    endfunction

    // Offer one transaction and hold it until the block takes it, then drop it.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [31:0] key,
                           input logic [31:0] val, input logic [5:0] pos);
        int idle;
        begin
            @(negedge clk);
            in_valid = 1'b1;
            func = op;
            search_key = key;
            new_value = val;
            position = pos;
            #1;
            while (in_stall)
            begin
                @(negedge clk);
                #1;
            end
            @(posedge clk);
            @(negedge clk);
            in_valid = 1'b0;
            idle = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            repeat (idle) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        begin
            if ($urandom_range(0, 9) < 7)
                pick_value = value_pool[$urandom_range(0, 11)];
            else
                pick_value = $urandom;
        end
    endfunction

    // Receiver back-pressure: short stalls mostly, a few long, some free runs.
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : gap_length();
            @(negedge clk);
            out_stall = 1'b0;
            repeat (run) @(negedge clk);
            out_stall = 1'b1;
            repeat (gap_length()) @(negedge clk);
        end
    end

    initial
    begin
        int          n;
        int          phase;
        int          roll;
        logic [FUNC_W-1:0] op;
        in_valid = 1'b0;
        func = FUNC_PUSH_FRONT;
        search_key = '0;
        new_value = '0;
        position = '0;
        sending_done = 1'b0;
        rst_n = 1'b0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < 12; n++)
            value_pool[n] = $urandom;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Empty-list corner cases
        send_op(FUNC_READ_AT, 0, 0, 6'd0);
        send_op(FUNC_POP_FRONT, 0, 0, 0);
        send_op(FUNC_POP_BACK, 0, 0, 0);
        send_op(FUNC_ERASE, 32'h5, 0, 0);
        send_op(FUNC_INSERT_BEFORE, 32'h0, 32'h7, 0);
        // Erase the only element
        send_op(FUNC_PUSH_BACK, 0, 32'h0, 0);
        send_op(FUNC_ERASE, 32'h0, 0, 0);
        send_op(FUNC_PUSH_FRONT, 0, 32'hFFFF_FFFF, 0);
        send_op(FUNC_PUSH_BACK, 0, 32'h0, 0);
        // Insert at the head, at the tail and in the middle
        send_op(FUNC_INSERT_BEFORE, 32'hFFFF_FFFF, 32'h1, 0);
        send_op(FUNC_INSERT_AFTER, 32'h0, 32'h2, 0);
        send_op(FUNC_INSERT_AFTER, 32'hFFFF_FFFF, 32'h3, 0);
        send_op(FUNC_INSERT_BEFORE, 32'h0, 32'hAAAA_AAAA, 0);
        send_op(FUNC_READ_AT, 0, 0, 6'd63);
        send_op(FUNC_READ_AT, 0, 0, 6'd2);
        send_op(FUNC_READ_AT, 0, 0, 6'd5);
        send_op(4'd15, 32'hFFFF_FFFF, 32'h5555_5555, 6'd42);
        send_op(4'd9, 0, 0, 0);
        send_op(FUNC_POP_FRONT, 0, 0, 0);
        send_op(FUNC_POP_BACK, 0, 0, 0);
        send_op(FUNC_ERASE, 32'h3, 0, 0);
        send_op(FUNC_CLEAR, 0, 0, 0);
        send_op(FUNC_CLEAR, 0, 0, 0);

        // Random phases: grow towards a full list, shrink, or mix
        phase = 0;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 60 == 0)
                phase = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = FUNC_W'($urandom_range(9, 15));
            else if (roll < 3)
                op = FUNC_CLEAR;
            else if (phase == 0)
                op = (roll < 70) ? FUNC_W'($urandom_range(0, 3))
                                 : FUNC_W'($urandom_range(4, 7));
            else if (phase == 1)
                op = (roll < 30) ? FUNC_W'($urandom_range(0, 3))
                                 : FUNC_W'($urandom_range(4, 7));
            else
                op = FUNC_W'($urandom_range(0, 7));
            send_op(op, pick_value(), pick_value(),
                    ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 15)));
        end
        @(negedge clk);
        in_valid = 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        wait (sending_done);
        while (pending_count != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
